// ===== rtl/ewo_pkg.sv =====
// ewo_pkg: shared types, constants and the cordic arctangent table for the
// wheel odometry block; used by every module under rtl

package ewo_pkg;

  // default parameter values
  localparam int unsigned COUNT_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // cordic datapath width (x, y and residual angle)
  localparam int unsigned CORDIC_W = 34;

  // 1/K of the cordic in q1.30
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;
  // binary-angle units per q4.28 radian, q30
  localparam logic [31:0] BAM_PER_RAD     = 32'd2734261102;

  // register file
  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_RIGHT_DPC  = 2'd0,
    REG_LEFT_DPC   = 2'd1,
    REG_INV_TRACK  = 2'd2,
    REG_SMALL_LIM  = 2'd3
  } reg_idx_e;

  localparam logic [31:0] RIGHT_DPC_RST = 32'd653148;
  localparam logic [31:0] LEFT_DPC_RST  = 32'd652643;
  localparam logic [31:0] INV_TRACK_RST = 32'd37688908;
  localparam logic [30:0] SMALL_LIM_RST = 31'd65766687;

  // status of a shared arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ewo_mul.sv =====
// ewo_mul: 64 x 64 bit product modulo 2^64 from one 32 x 32 multiplier,
// three partial products in turn; depends on ewo_pkg

module ewo_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output ewo_pkg::unit_stat_t stat_o,
  output logic [63:0]         prod_o
);
  import ewo_pkg::*;

  typedef enum logic [1:0] {
    PH_LL = 2'd0,
    PH_LH = 2'd1,
    PH_HL = 2'd2
  } mul_phase_e;

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;
  mul_phase_e  ph_q;
  logic        busy_q, done_q;

  always_comb begin
    case (ph_q)
      PH_LL:   begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
      PH_LH:   begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
      PH_HL:   begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
      default: begin op_a = '0;         op_b = '0;         end
    endcase
    pp = op_a * op_b;
    if (ph_q == PH_LL) begin
      acc_d = pp;
    end else begin
      acc_d = acc_q + {pp[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PH_LL;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        ph_q   <= PH_LL;
      end else if (busy_q) begin
        unique case (ph_q)
          PH_LL: ph_q <= PH_LH;
          PH_LH: ph_q <= PH_HL;
          PH_HL: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            ph_q   <= PH_LL;
          end
          default: ph_q <= PH_LL;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = acc_q;

endmodule

// ===== rtl/ewo_cordic.sv =====
// ewo_cordic: rotation-mode cordic, one micro-rotation per cycle, giving
// cosine and sine of a binary angle in q1.30; depends on ewo_pkg

module ewo_cordic #(
  parameter int unsigned STEPS = ewo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [31:0]                          ang_i,
  output ewo_pkg::unit_stat_t                  stat_o,
  output logic signed [ewo_pkg::CORDIC_W-1:0]  cos_o,
  output logic signed [ewo_pkg::CORDIC_W-1:0]  sin_o
);
  import ewo_pkg::*;

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic signed [CORDIC_W-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [CORDIC_W-1:0] dx, dy, at;
  logic [4:0]  i_q;
  logic        flip_q, busy_q, done_q;
  logic        flip_in;
  logic [31:0] ang_red;

  assign flip_in = ang_i[31] ^ ang_i[30];
  assign ang_red = flip_in ? (ang_i ^ 32'h80000000) : ang_i;

  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = $signed({2'b00, atan_bam(i_q)});
    if (!z_q[CORDIC_W-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      x_q    <= CORDIC_W'(CORDIC_GAIN_INV);
      y_q    <= '0;
      z_q    <= $signed({{(CORDIC_W-32){ang_red[31]}}, ang_red});
      flip_q <= flip_in;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/ewo_div.sv =====
// ewo_div: restoring divider, 64-bit dividend by 31-bit divisor, one
// quotient bit per cycle; depends on ewo_pkg

module ewo_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         dividend_i,
  input  logic [30:0]         divisor_i,
  output ewo_pkg::unit_stat_t stat_o,
  output logic [63:0]         quot_o
);
  import ewo_pkg::*;

  logic [63:0] n_q;
  logic [31:0] rem_q, trial, rem_d;
  logic [30:0] d_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, ge;

  always_comb begin
    trial = {rem_q[30:0], n_q[63]};
    ge    = trial >= {1'b0, d_q};
    rem_d = ge ? (trial - {1'b0, d_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      n_q   <= dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      n_q   <= {n_q[62:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quot_o = n_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/encoder_wheel_odometry.sv =====
// encoder_wheel_odometry: top level, sequencer, pose state and register file
// depends on ewo_pkg, ewo_mul, ewo_cordic and ewo_div
//
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tdata: sample_time_ms, right_count, left_count
//  m_axis    | out       | tdata: pos_x, pos_y, heading, elapsed_ms,
//            |           |        right_step, left_step
//  apb       | in / out  | four 32-bit registers at byte addresses 0..12
//
//  the arc length path skips the first cordic run, the divider and the chord
//  product; in the chord path the divider and each cordic run dominate, and each
//  product runs on the one 32 x 32 multiplier that all products share
//  s_axis_tready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next sample runs, the sequencer stalls
//  at its end until it is free; reset clears pose and last sample, presets registers

module encoder_wheel_odometry #(
  parameter int unsigned COUNT_WIDTH  = ewo_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = ewo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ewo_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input samples
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // sample_time_ms[15:0], right_count[31:16], left_count[47:32]
  input  logic [47:0]                s_axis_tdata,
  // pose results
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[95:64], elapsed_ms[111:96],
  // right_step[143:112], left_step[175:144]
  output logic [175:0]               m_axis_tdata
);
  import ewo_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;
  localparam logic [63:0] HALF_LSB30 = 64'd536870912;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'h001,
    ST_DIST_R = 12'h002,
    ST_DIST_L = 12'h004,
    ST_YAW    = 12'h008,
    ST_BAM    = 12'h010,
    ST_COR1   = 12'h020,
    ST_DIV    = 12'h040,
    ST_CHORD  = 12'h080,
    ST_COR2   = 12'h100,
    ST_PX     = 12'h200,
    ST_PY     = 12'h400,
    ST_OUT    = 12'h800
  } state_e;

  // wrapped counter difference, corrected when beyond a tenth of full scale
  function automatic logic signed [CW:0] wrap_diff(input logic [CW-1:0] now,
                                                   input logic [CW-1:0] last);
    logic signed [CW+5:0] d, ten, full;
    d    = $signed({6'd0, now}) - $signed({6'd0, last});
    ten  = (d <<< 3) + (d <<< 1);
    full = $signed((CW+6)'(1) << CW);
    if (ten > full) begin
      d = d - full;
    end else if (ten < -full) begin
      d = d + full;
    end
    return d[CW:0];
  endfunction

  // round half away from zero to q16.16 and reapply sign
  function automatic logic signed [49:0] to_dist(input logic [63:0] p,
                                                 input logic neg);
    logic [48:0] q;
    q = {1'b0, p[63:16]} + {48'd0, p[15]};
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    if (v > S32_MAX) begin
      return 32'h7FFFFFFF;
    end else if (v < S32_MIN) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // registers
  logic [31:0] rdpc_q, ldpc_q, inv_tw_q;
  logic [30:0] lim_q;
  logic        cfg_wr;

  // previous sample and pose
  logic [15:0]   last_t_q;
  logic [CW-1:0] last_r_q, last_l_q;
  logic [31:0]   acc_x_q, acc_y_q, acc_h_q;

  // per-sample working registers
  state_e              state_q, state_d;
  logic                launched_q, launched_d;
  logic [15:0]         elapsed_q;
  logic signed [CW:0]  dr_q, dl_q;
  logic [31:0]         rs_q, ls_q;
  logic                diff_neg_q, small_q, sin_neg_q;
  logic [30:0]         m_q;
  logic [31:0]         full_q, half_q;
  logic [63:0]         dist_q, f_q;
  logic signed [CORDIC_W-1:0] c_q, s_q;

  // output register
  logic         out_valid_q;
  logic [175:0] out_data_q;

  // inputs
  logic [15:0]   in_t, in_r, in_l;
  logic [CW+15:0] r_ext, l_ext;
  logic [CW-1:0] r_now, l_now;
  logic          s_accept;

  // shared units
  logic        mul_start, cor_start, div_start;
  logic [63:0] mul_a, mul_b, mul_p, quot;
  logic [31:0] cor_ang;
  logic signed [CORDIC_W-1:0] cor_c, cor_s;
  unit_stat_t  mul_stat, cor_stat, div_stat;

  // datapath helpers
  logic [CW:0]         dr_mag, dl_mag;
  logic signed [32:0]  diff, lsum;
  logic [32:0]         dmag33;
  logic [31:0]         linear;
  logic [52:0]         m53;
  logic [30:0]         m_sat;
  logic                small_now;
  logic [31:0]         full_now, half_now;
  logic [CORDIC_W-1:0] smag;
  logic [63:0]         rnd;

  assign in_t  = s_axis_tdata[15:0];
  assign in_r  = s_axis_tdata[31:16];
  assign in_l  = s_axis_tdata[47:32];
  assign r_ext = {{CW{1'b0}}, in_r};
  assign l_ext = {{CW{1'b0}}, in_l};
  assign r_now = r_ext[CW-1:0];
  assign l_now = l_ext[CW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // configuration port, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_RIGHT_DPC: prdata = rdpc_q;
      REG_LEFT_DPC:  prdata = ldpc_q;
      REG_INV_TRACK: prdata = inv_tw_q;
      REG_SMALL_LIM: prdata = {1'b0, lim_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdpc_q   <= RIGHT_DPC_RST;
      ldpc_q   <= LEFT_DPC_RST;
      inv_tw_q <= INV_TRACK_RST;
      lim_q    <= SMALL_LIM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_RIGHT_DPC: rdpc_q   <= pwdata;
        REG_LEFT_DPC:  ldpc_q   <= pwdata;
        REG_INV_TRACK: inv_tw_q <= pwdata;
        REG_SMALL_LIM: lim_q    <= pwdata[30:0];
        default:       ;
      endcase
    end
  end

  // combinational helpers around the shared units
  always_comb begin
    dr_mag    = dr_q[CW] ? (CW+1)'(-dr_q) : dr_q;
    dl_mag    = dl_q[CW] ? (CW+1)'(-dl_q) : dl_q;
    diff      = $signed({rs_q[31], rs_q}) - $signed({ls_q[31], ls_q});
    dmag33    = diff[32] ? 33'(-diff) : diff;
    lsum      = $signed({rs_q[31], rs_q}) + $signed({ls_q[31], ls_q});
    linear    = lsum[32:1];
    // yaw magnitude rounded to q4.28 and saturated
    m53       = mul_p[63:12] + {52'd0, mul_p[11]};
    m_sat     = (m53 > 53'h7FFFFFFF) ? 31'h7FFFFFFF : m53[30:0];
    small_now = mul_p < {21'd0, lim_q, 12'd0};
    // binary angle of the full and the half yaw
    full_now  = mul_p[61:30] + {31'd0, mul_p[29]};
    half_now  = mul_p[62:31] + {31'd0, mul_p[30]};
    smag      = s_q[CORDIC_W-1] ? -s_q : s_q;
    rnd       = mul_p + HALF_LSB30;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DIST_R: begin mul_a = 64'(dr_mag); mul_b = {32'd0, rdpc_q}; end
      ST_DIST_L: begin mul_a = 64'(dl_mag); mul_b = {32'd0, ldpc_q}; end
      ST_YAW:    begin mul_a = {32'd0, dmag33[31:0]}; mul_b = {32'd0, inv_tw_q}; end
      ST_BAM:    begin mul_a = {33'd0, m_q}; mul_b = {32'd0, BAM_PER_RAD}; end
      ST_CHORD:  begin mul_a = {{32{linear[31]}}, linear}; mul_b = f_q; end
      ST_PX:     begin mul_a = dist_q; mul_b = 64'(c_q); end
      ST_PY:     begin mul_a = dist_q; mul_b = 64'(s_q); end
      default:   ;
    endcase
  end

  assign cor_ang = (state_q == ST_COR1) ? half_q : (acc_h_q + half_q);

  assign mul_start = !launched_q && (state_q == ST_DIST_R || state_q == ST_DIST_L ||
                     state_q == ST_YAW || state_q == ST_BAM || state_q == ST_CHORD ||
                     state_q == ST_PX || state_q == ST_PY);
  assign cor_start = !launched_q && (state_q == ST_COR1 || state_q == ST_COR2);
  assign div_start = !launched_q && (state_q == ST_DIV);

  // sequencer
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    if (mul_start || cor_start || div_start) begin
      launched_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: if (s_accept) state_d = ST_DIST_R;
      ST_DIST_R: if (mul_stat.done) begin
        state_d = ST_DIST_L; launched_d = 1'b0;
      end
      ST_DIST_L: if (mul_stat.done) begin
        state_d = ST_YAW; launched_d = 1'b0;
      end
      ST_YAW: if (mul_stat.done) begin
        state_d = ST_BAM; launched_d = 1'b0;
      end
      ST_BAM: if (mul_stat.done) begin
        // arc length below the limit or for zero yaw, chord otherwise
        state_d    = (small_q || m_q == '0) ? ST_COR2 : ST_COR1;
        launched_d = 1'b0;
      end
      ST_COR1: if (cor_stat.done) begin
        state_d = ST_DIV; launched_d = 1'b0;
      end
      ST_DIV: if (div_stat.done) begin
        state_d = ST_CHORD; launched_d = 1'b0;
      end
      ST_CHORD: if (mul_stat.done) begin
        state_d = ST_COR2; launched_d = 1'b0;
      end
      ST_COR2: if (cor_stat.done) begin
        state_d = ST_PX; launched_d = 1'b0;
      end
      ST_PX: if (mul_stat.done) begin
        state_d = ST_PY; launched_d = 1'b0;
      end
      ST_PY: if (mul_stat.done) begin
        state_d = ST_OUT; launched_d = 1'b0;
      end
      ST_OUT: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: begin
        state_d    = ST_IDLE;
        launched_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_t_q    <= '0;
      last_r_q    <= '0;
      last_l_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s_accept) begin
        last_t_q <= in_t;
        last_r_q <= r_now;
        last_l_q <= l_now;
      end
      if (state_q == ST_PX && mul_stat.done) begin
        acc_x_q <= acc_x_q + rnd[61:30];
      end
      if (state_q == ST_PY && mul_stat.done) begin
        acc_y_q <= acc_y_q + rnd[61:30];
        acc_h_q <= acc_h_q + full_q;
      end
    end
  end

  // working registers of the current sample
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      elapsed_q <= in_t - last_t_q;
      dr_q      <= wrap_diff(r_now, last_r_q);
      dl_q      <= wrap_diff(l_now, last_l_q);
    end
    if (state_q == ST_DIST_R && mul_stat.done) begin
      rs_q <= sat32(to_dist(mul_p, dr_q[CW]));
    end
    if (state_q == ST_DIST_L && mul_stat.done) begin
      // left wheel is mounted mirrored, distance negated
      ls_q <= sat32(to_dist(mul_p, !dl_q[CW]));
    end
    if (state_q == ST_YAW && mul_stat.done) begin
      diff_neg_q <= diff[32];
      small_q    <= small_now;
      m_q        <= m_sat;
    end
    if (state_q == ST_BAM && mul_stat.done) begin
      full_q <= diff_neg_q ? -full_now : full_now;
      half_q <= diff_neg_q ? -half_now : half_now;
      dist_q <= {{32{linear[31]}}, linear};
    end
    if (state_q == ST_COR1 && cor_stat.done) begin
      s_q <= cor_s;
    end
    if (state_q == ST_COR1 || state_q == ST_DIV) begin
      sin_neg_q <= s_q[CORDIC_W-1];
    end
    if (state_q == ST_DIV && div_stat.done) begin
      f_q <= (sin_neg_q != diff_neg_q) ? -quot : quot;
    end
    if (state_q == ST_CHORD && mul_stat.done) begin
      dist_q <= {{30{rnd[63]}}, rnd[63:30]};
    end
    if (state_q == ST_COR2 && cor_stat.done) begin
      c_q <= cor_c;
      s_q <= cor_s;
    end
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {ls_q, rs_q, elapsed_q, acc_h_q, acc_y_q, acc_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  ewo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_p)
  );

  ewo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (cor_ang),
    .stat_o  (cor_stat),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  ewo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (64'(smag) << 29),
    .divisor_i  (m_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  // an accepted sample always starts with the right wheel product
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == ST_DIST_R)
    else $error("sample accepted but sequencer did not start");

  // the divider never runs on a zero yaw
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> m_q != '0)
    else $error("divider started with zero divisor");

  // x only moves when the x product completes
  a_x_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(acc_x_q) |-> $past(state_q == ST_PX && mul_stat.done))
    else $error("x accumulator changed outside its update");

  // no unit is launched while another one is still working
  a_single_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_start || cor_start || div_start) |->
      !mul_stat.busy && !cor_stat.busy && !div_stat.busy)
    else $error("shared unit launched while busy");

endmodule

// ===== bench/encoder_wheel_odometry_test.sv =====
// encoder_wheel_odometry_test: self-checking bench for the wheel odometry block
// drives samples on s_axis and register writes on apb, checks m_axis poses
// against a bit-exact pose predictor or a hand-typed pose; depends on ewo_pkg and the rtl top level
`timescale 1ns / 100ps

module encoder_wheel_odometry_test;
  import ewo_pkg::*;

  typedef longint unsigned u64_t;

  // one pose transaction, packed so that pos_x lands in the lowest bits
  typedef struct packed {
    logic [31:0] left_step;
    logic [31:0] right_step;
    logic [15:0] elapsed_ms;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  // directed stimulus row; known rows carry a hand-typed pose
  typedef struct {
    logic [15:0] t_ms;
    logic [15:0] r_cnt;
    logic [15:0] l_cnt;
    bit          known;
    pose_t       pose;
  } sample_row_t;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS  = 165;

  logic         clk_i;
  logic         rst_ni;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // sample_time_ms[15:0], right_count[31:16], left_count[47:32]
  logic [47:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // pos_x[31:0], pos_y[63:32], heading[95:64], elapsed_ms[111:96],
  // right_step[143:112], left_step[175:144]
  logic [175:0] m_axis_tdata;

  encoder_wheel_odometry u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // pose predictor: shadow registers and state
  // ---------------------------------------------------------------------
  logic [31:0] shadow_rdpc, shadow_ldpc, shadow_itw;
  logic [30:0] shadow_lim;
  logic [15:0] prev_t, prev_r, prev_l;
  logic [31:0] pose_x, pose_y, pose_h;

  pose_t expected_poses[$];
  int unsigned mismatches;
  int unsigned poses_seen;
  int unsigned cycles;
  bit          noisy;

  // wrapped counter step; a jump beyond a tenth of full scale is a wrap
  function automatic longint count_delta(logic [15:0] now, logic [15:0] last);
    longint d;
    d = longint'(now) - longint'(last);
    if (d * 10 > 65536) d -= 65536;
    else if (d * 10 < -65536) d += 65536;
    return d;
  endfunction

  // counts times metres per count, q16.16 rounded half away from zero
  function automatic longint wheel_dist(longint d, logic [31:0] k);
    u64_t mag, p, q;
    mag = (d < 0) ? u64_t'(-d) : u64_t'(d);
    p = mag * u64_t'(k);
    q = (p >> 16) + ((p >> 15) & 64'd1);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round30(longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  // cos and sin of a binary angle in q1.30, rotation mode cordic
  function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                  output longint s);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'($signed(ang));
    x = longint'(CORDIC_GAIN_INV);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_bam(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_bam(i[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  // advance the shadow pose by one sample and return the expected transaction
  function automatic pose_t predict_pose(logic [15:0] t, logic [15:0] r, logic [15:0] l);
    pose_t  res;
    longint rs, ls, diff, lin, travel, c, s, f;
    u64_t   dmag, p, m, mb, smag, fm;
    logic   small_yaw;
    logic [31:0] full_bam, half_bam;
    rs = sat32(wheel_dist(count_delta(r, prev_r), shadow_rdpc));
    ls = sat32(-wheel_dist(count_delta(l, prev_l), shadow_ldpc));
    diff = rs - ls;
    dmag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
    p = dmag * u64_t'(shadow_itw);
    small_yaw = p < (u64_t'(shadow_lim) << 12);
    // yaw in q4.28 radians, saturated near 8 rad
    m = (p >> 12) + ((p >> 11) & 64'd1);
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    mb = m * u64_t'(BAM_PER_RAD);
    full_bam = 32'((mb >> 30) + ((mb >> 29) & 64'd1));
    half_bam = 32'((mb >> 31) + ((mb >> 30) & 64'd1));
    if (diff < 0) begin
      full_bam = -full_bam;
      half_bam = -half_bam;
    end
    lin = (rs + ls) >>> 1;
    // arc length below the limit or for zero yaw, chord above it
    if (small_yaw || m == 0) begin
      travel = lin;
    end else begin
      sin_cos(half_bam, c, s);
      smag = (s < 0) ? u64_t'(-s) : u64_t'(s);
      fm = (smag << 29) / m;
      f = ((s < 0) != (diff < 0)) ? -longint'(fm) : longint'(fm);
      travel = round30(lin * f);
    end
    sin_cos(pose_h + half_bam, c, s);
    pose_x = pose_x + 32'(round30(travel * c));
    pose_y = pose_y + 32'(round30(travel * s));
    pose_h = pose_h + full_bam;
    res.pos_x      = pose_x;
    res.pos_y      = pose_y;
    res.heading    = pose_h;
    res.elapsed_ms = t - prev_t;
    res.right_step = 32'(rs);
    res.left_step  = 32'(ls);
    prev_t = t;
    prev_r = r;
    prev_l = l;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // apb write: setup cycle, access cycle, register taken at the access edge
  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RIGHT_DPC: shadow_rdpc = value;
      REG_LEFT_DPC:  shadow_ldpc = value;
      REG_INV_TRACK: shadow_itw  = value;
      REG_SMALL_LIM: shadow_lim  = value[30:0];
      default: ;
    endcase
  endtask

  // offer one sample; valid stays high after acceptance so back-to-back
  // transactions see no low pulse unless noisy mode inserts a random gap
  task automatic send_sample(logic [15:0] t, logic [15:0] r, logic [15:0] l,
                             bit known, pose_t typed);
    pose_t pred;
    if (noisy && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {l, r, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_pose(t, r, l);
    expected_poses.push_back(known ? typed : pred);
  endtask

  // hold off the sender until every pose is back, then let the block settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall bursts plus one long hold-off that backs the
  // block up into its input
  // ---------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && poses_seen == 40) begin
      hold_done     <= 1'b1;
      hold_left     <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (noisy && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // pose checker
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pose_t'(m_axis_tdata);
      poses_seen <= poses_seen + 1;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("pose with nothing expected: %h", m_axis_tdata);
      end else begin
        want = expected_poses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pose %0d mismatch", poses_seen);
            $display("  pos_x   exp %h got %h", want.pos_x, got.pos_x);
            $display("  pos_y   exp %h got %h", want.pos_y, got.pos_y);
            $display("  heading exp %h got %h", want.heading, got.heading);
            $display("  elapsed exp %h got %h", want.elapsed_ms, got.elapsed_ms);
            $display("  r_step  exp %h got %h", want.right_step, got.right_step);
            $display("  l_step  exp %h got %h", want.left_step, got.left_step);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // directed table: reset state, straight runs, turns, the tenth-of-scale
  // wrap boundary on both sides, counter and time extremes
  // ---------------------------------------------------------------------
  sample_row_t directed[] = '{
    // first sample after reset, differences against zero: all zero
    '{16'd0,     16'd0,     16'd0,     1'b1, '0},
    // time only moves
    '{16'd7,     16'd0,     16'd0,     1'b1, '{32'd0, 32'd0, 16'd7, 32'd0, 32'd0, 32'd0}},
    '{16'd17,    16'd100,   16'd65436, 1'b0, '0},
    '{16'd27,    16'd200,   16'd65336, 1'b0, '0},
    '{16'd30,    16'd3200,  16'd65336, 1'b0, '0},
    '{16'd40,    16'd6200,  16'd2664,  1'b0, '0},
    // right step just below a tenth of full scale, then just past it
    '{16'd60,    16'd12753, 16'd2664,  1'b0, '0},
    '{16'd70,    16'd19307, 16'd2664,  1'b0, '0},
    '{16'd65535, 16'd19307, 16'd0,     1'b0, '0},
    // time and counters wrap past zero
    '{16'd3,     16'hFFFF,  16'hFFFF,  1'b0, '0},
    '{16'd4,     16'h0000,  16'h0000,  1'b0, '0},
    '{16'd5,     16'h8000,  16'h8000,  1'b0, '0},
    '{16'd6,     16'h0000,  16'h7FFF,  1'b0, '0},
    '{16'd9,     16'h0001,  16'hFFFF,  1'b0, '0},
    '{16'hFFFF,  16'hFFFF,  16'h0000,  1'b0, '0},
    '{16'h0000,  16'h199A,  16'hE666,  1'b0, '0},
    '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '0}
  };

  initial begin
    logic [15:0] t, r, l;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    poses_seen    = 0;
    cycles        = 0;
    noisy         = 1'b1;
    shadow_rdpc   = RIGHT_DPC_RST;
    shadow_ldpc   = LEFT_DPC_RST;
    shadow_itw    = INV_TRACK_RST;
    shadow_lim    = SMALL_LIM_RST;
    prev_t = '0; prev_r = '0; prev_l = '0;
    pose_x = '0; pose_y = '0; pose_h = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_sample(directed[i].t_ms, directed[i].r_cnt, directed[i].l_cnt,
                  directed[i].known, directed[i].pose);
    t = prev_t; r = prev_r; l = prev_l;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // register settings change only with the block idle
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin  // all zero: no distance at all, limit zero
            reg_write(REG_RIGHT_DPC, 32'd0);
            reg_write(REG_LEFT_DPC,  32'd0);
            reg_write(REG_INV_TRACK, 32'd0);
            reg_write(REG_SMALL_LIM, 32'd0);
          end
          2: begin  // all ones: saturated steps, top bit of limit dropped
            reg_write(REG_RIGHT_DPC, 32'hFFFF_FFFF);
            reg_write(REG_LEFT_DPC,  32'hFFFF_FFFF);
            reg_write(REG_INV_TRACK, 32'hFFFF_FFFF);
            reg_write(REG_SMALL_LIM, 32'hFFFF_FFFF);
          end
          3: begin  // default geometry, chord on every turn
            reg_write(REG_RIGHT_DPC, RIGHT_DPC_RST);
            reg_write(REG_LEFT_DPC,  LEFT_DPC_RST);
            reg_write(REG_INV_TRACK, INV_TRACK_RST);
            reg_write(REG_SMALL_LIM, 32'd0);
          end
          4: begin  // random geometry
            reg_write(REG_RIGHT_DPC, $urandom_range(0, 32'h00FF_FFFF));
            reg_write(REG_LEFT_DPC,  $urandom_range(0, 32'h00FF_FFFF));
            reg_write(REG_INV_TRACK, $urandom);
            reg_write(REG_SMALL_LIM, $urandom_range(0, 32'h0800_0000));
          end
          default: begin  // last part: defaults back, no idling
            reg_write(REG_RIGHT_DPC, RIGHT_DPC_RST);
            reg_write(REG_LEFT_DPC,  LEFT_DPC_RST);
            reg_write(REG_INV_TRACK, INV_TRACK_RST);
            reg_write(REG_SMALL_LIM, 32'(SMALL_LIM_RST));
            noisy = 1'b0;
          end
        endcase
      end
      // mostly plausible motion, now and then an arbitrary sample
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) t = 16'($urandom);
        else t = t + 16'($urandom_range(1, 20));
        if ($urandom_range(0, 7) == 0) begin
          r = 16'($urandom);
          l = 16'($urandom);
        end else begin
          r = r + 16'($urandom_range(0, 8000)) - 16'd4000;
          l = l + 16'($urandom_range(0, 8000)) - 16'd4000;
        end
        send_sample(t, r, l, 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ewo_pkg.sv
rtl/ewo_mul.sv
rtl/ewo_cordic.sv
rtl/ewo_div.sv
rtl/encoder_wheel_odometry.sv
bench/encoder_wheel_odometry_test.sv
